// File: design/trdr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the transpose descriptor reducer.
// No dependencies; every other design file refers to this package by scope.
package trdr_pkg;

    localparam int MAX_IN_RANK = 5;
    localparam int OUT_RANK    = 4;
    localparam int WORK        = MAX_IN_RANK + 1;   // survivors plus byte dimension
    localparam int DIM_W       = 16;
    localparam int PERM_W      = 3;
    localparam int EB_W        = 4;
    localparam int VAL_W       = 32;                // values up to and including 2^31
    localparam int FIELD_W     = 31;
    localparam int IDX_W       = 3;
    localparam int OIDX_W      = 2;

    localparam logic [VAL_W-1:0] CAP31 = 32'h8000_0000;

    typedef logic [VAL_W-1:0]  val_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [1:0]        status_t;

    localparam status_t STATUS_OK   = 2'd0;
    localparam status_t STATUS_RANK = 2'd1;
    localparam status_t STATUS_OVF  = 2'd2;

    // Compacted shape and permutation handed from the front end to the sequencer
    typedef struct packed {
        logic [WORK-1:0][VAL_W-1:0] shp;
        logic [WORK-1:0][IDX_W-1:0] pr;
        logic [IDX_W-1:0]           n;
    } prep_t;

endpackage

// File: design/trdr_satmul.sv
`timescale 1ns / 1ps
// Shared saturating multiplier: 32 x 32 product clamped at 2^31.
// Depends on trdr_pkg.
module trdr_satmul (
    input  trdr_pkg::val_t a,
    input  trdr_pkg::val_t b,
    output trdr_pkg::val_t y
);

    logic [2*trdr_pkg::VAL_W-1:0] prod;

    assign prod = (2*trdr_pkg::VAL_W)'(a) * (2*trdr_pkg::VAL_W)'(b);

    // clamp anything above 2^31 back to 2^31
    assign y = (prod > (2*trdr_pkg::VAL_W)'(trdr_pkg::CAP31)) ? trdr_pkg::CAP31
                                                                : prod[trdr_pkg::VAL_W-1:0];

endmodule

// File: design/trdr_prep.sv
`timescale 1ns / 1ps
// Front end: validate the permutation, drop unit dimensions, remap the
// permutation onto survivors and append the byte dimension. Depends on trdr_pkg.
module trdr_prep (
    input  logic [trdr_pkg::IDX_W-1:0]                               rank,
    input  logic [trdr_pkg::MAX_IN_RANK-1:0][trdr_pkg::DIM_W-1:0]    dim_vec,
    input  logic [trdr_pkg::MAX_IN_RANK-1:0][trdr_pkg::PERM_W-1:0]   perm_vec,
    input  logic [trdr_pkg::EB_W-1:0]                                elem_bytes,
    output trdr_pkg::prep_t                                          prep
);

    logic [trdr_pkg::IDX_W-1:0]       r;
    logic [trdr_pkg::MAX_IN_RANK-1:0] seen;
    logic                             perm_ok;
    logic [trdr_pkg::PERM_W-1:0]      perm_eff [trdr_pkg::MAX_IN_RANK];
    logic [trdr_pkg::MAX_IN_RANK-1:0] surv;
    logic [trdr_pkg::IDX_W-1:0]       map [trdr_pkg::MAX_IN_RANK];
    logic [trdr_pkg::IDX_W-1:0]       cnt;
    logic [trdr_pkg::IDX_W-1:0]       m;

    always_comb
    begin
        r = (rank > trdr_pkg::IDX_W'(trdr_pkg::MAX_IN_RANK))
            ? trdr_pkg::IDX_W'(trdr_pkg::MAX_IN_RANK) : rank;

        // a bad permutation falls back to identity
        seen    = '0;
        perm_ok = 1'b1;
        for (int i = 0; i < trdr_pkg::MAX_IN_RANK; i++)
        begin
            if (trdr_pkg::IDX_W'(i) < r)
            begin
                if (perm_vec[i] >= r || seen[perm_vec[i]])
                    perm_ok = 1'b0;
                else
                    seen[perm_vec[i]] = 1'b1;
            end
        end

        for (int i = 0; i < trdr_pkg::MAX_IN_RANK; i++)
        begin
            perm_eff[i] = perm_ok ? perm_vec[i] : trdr_pkg::PERM_W'(i);
            surv[i]     = (trdr_pkg::IDX_W'(i) < r) && (dim_vec[i] != trdr_pkg::DIM_W'(1));
        end

        prep.shp = '0;
        prep.pr  = '0;

        // compact the non-unit extents
        cnt = '0;
        for (int i = 0; i < trdr_pkg::MAX_IN_RANK; i++)
        begin
            map[i] = cnt;
            if (surv[i])
            begin
                prep.shp[cnt] = trdr_pkg::VAL_W'(dim_vec[i]);
                cnt           = cnt + trdr_pkg::IDX_W'(1);
            end
        end

        // remap the permutation onto the compacted positions
        m = '0;
        for (int i = 0; i < trdr_pkg::MAX_IN_RANK; i++)
        begin
            if (trdr_pkg::IDX_W'(i) < r && surv[perm_eff[i]])
            begin
                prep.pr[m] = map[perm_eff[i]];
                m          = m + trdr_pkg::IDX_W'(1);
            end
        end

        prep.n = cnt;
        // all extents were one: reduce to a single unit dimension
        if (cnt == '0)
        begin
            prep.shp[0] = trdr_pkg::VAL_W'(1);
            prep.pr[0]  = '0;
            prep.n      = trdr_pkg::IDX_W'(1);
        end

        // the byte dimension always stays innermost
        if (elem_bytes > trdr_pkg::EB_W'(1))
        begin
            prep.shp[prep.n] = trdr_pkg::VAL_W'(elem_bytes);
            prep.pr[prep.n]  = prep.n;
            prep.n           = prep.n + trdr_pkg::IDX_W'(1);
        end
    end

endmodule

// File: design/transpose_descriptor_reducer_unit.sv
`timescale 1ns / 1ps
// Transpose descriptor reducer, top level: sequencer around the shared
// saturating multiplier. Depends on trdr_pkg, trdr_prep and trdr_satmul.
//
// Usage
//   Request channel (req_valid / req_stall) carries one shape, permutation and
//   element size per transaction. Response channel (rsp_valid / rsp_stall)
//   returns status, four source strides and four extents per transaction.
//   Exactly one response follows every request, in order.
// Sequence
//   The shared multiplier serves both the merge loop and the stride chain, so
//   the work follows the number of merges M (0 to 5). Each merge passes a scan
//   state (search and multiply) and then a collapse state; strides take three
//   multiplier passes, and the permuted gather fills the four lanes one at a
//   time. When more than four dimensions remain, the padding, stride and
//   gather states are skipped.
// Throughput
//   One request at a time: req_stall is high from the request edge until the
//   result moves into the output register.
//   A held response does not block the next request, only its completion.
// Reset
//   rst_n clears the sequencer and the response valid; nothing is pending.
// Receiver stall
//   The output register holds its transaction; a finished result waits in the
//   last state until the register frees up.
module transpose_descriptor_reducer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  rank,
    input  logic [15:0] dim0,
    input  logic [15:0] dim1,
    input  logic [15:0] dim2,
    input  logic [15:0] dim3,
    input  logic [15:0] dim4,
    input  logic [2:0]  perm0,
    input  logic [2:0]  perm1,
    input  logic [2:0]  perm2,
    input  logic [2:0]  perm3,
    input  logic [2:0]  perm4,
    input  logic [3:0]  elem_bytes,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [30:0] stride0,
    output logic [30:0] stride1,
    output logic [30:0] stride2,
    output logic [30:0] stride3,
    output logic [30:0] tshape0,
    output logic [30:0] tshape1,
    output logic [30:0] tshape2,
    output logic [30:0] tshape3
);

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b000_0001,
        ST_SCAN     = 7'b000_0010,
        ST_COLLAPSE = 7'b000_0100,
        ST_PAD      = 7'b000_1000,
        ST_STRIDE   = 7'b001_0000,
        ST_PERM     = 7'b010_0000,
        ST_DONE     = 7'b100_0000
    } state_t;

    localparam int WORK    = trdr_pkg::WORK;
    localparam int ORANK   = trdr_pkg::OUT_RANK;
    localparam int VAL_W   = trdr_pkg::VAL_W;
    localparam int IDX_W   = trdr_pkg::IDX_W;
    localparam int OIDX_W  = trdr_pkg::OIDX_W;
    localparam int FIELD_W = trdr_pkg::FIELD_W;

    // control
    state_t              state_reg, state_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [OIDX_W-1:0]   cnt_reg, cnt_next;
    logic                out_load;

    // working shape and permutation
    logic [WORK-1:0][VAL_W-1:0] shp_reg;
    logic [WORK-1:0][IDX_W-1:0] pr_reg;
    logic [IDX_W-1:0]           n_reg;

    // merge bookkeeping
    trdr_pkg::val_t   prod_reg;
    logic [IDX_W-1:0] k_reg;
    logic [IDX_W-1:0] p1_reg;

    // padded shape, permutation and strides
    logic [ORANK-1:0][VAL_W-1:0]  s_reg;
    logic [ORANK-1:0][OIDX_W-1:0] fp_reg;
    logic [ORANK-1:0][VAL_W-1:0]  off_reg;
    trdr_pkg::val_t               acc_reg;
    trdr_pkg::status_t            stat_reg;

    // staged and presented results
    logic [ORANK-1:0][FIELD_W-1:0] stg_stride_reg;
    logic [ORANK-1:0][FIELD_W-1:0] stg_tshape_reg;
    trdr_pkg::status_t             out_status_reg;
    logic [ORANK-1:0][FIELD_W-1:0] out_stride_reg;
    logic [ORANK-1:0][FIELD_W-1:0] out_tshape_reg;

    // front end
    trdr_pkg::prep_t prep;

    trdr_prep u_prep (
        .rank       (rank),
        .dim_vec    ({dim4, dim3, dim2, dim1, dim0}),
        .perm_vec   ({perm4, perm3, perm2, perm1, perm0}),
        .elem_bytes (elem_bytes),
        .prep       (prep)
    );

    // search for the first mergeable pair and pick its operands
    logic             found;
    logic [IDX_W-1:0] k_sel;
    logic [IDX_W-1:0] p1_sel;
    trdr_pkg::val_t   merge_a;
    trdr_pkg::val_t   merge_b;

    always_comb
    begin
        found = 1'b0;
        k_sel = '0;
        for (int i = 0; i < WORK - 1; i++)
        begin
            if (!found && (IDX_W'(i + 1) < n_reg)
                && (pr_reg[i] + IDX_W'(1) == pr_reg[i + 1]))
            begin
                found = 1'b1;
                k_sel = IDX_W'(i);
            end
        end
        p1_sel  = pr_reg[k_sel];
        merge_a = '0;
        merge_b = '0;
        // merged entries are always neighbors in the shape: lanes p1 and p1+1
        for (int j = 0; j < WORK - 1; j++)
        begin
            if (p1_sel == IDX_W'(j))
            begin
                merge_a = shp_reg[j];
                merge_b = shp_reg[j + 1];
            end
        end
    end

    // shared multiplier
    trdr_pkg::val_t mul_a, mul_b, mul_y;

    assign mul_a = (state_reg == ST_SCAN) ? merge_a : acc_reg;
    assign mul_b = (state_reg == ST_SCAN) ? merge_b : s_reg[cnt_reg];

    trdr_satmul u_mul (
        .a (mul_a),
        .b (mul_b),
        .y (mul_y)
    );

    // collapse: write the product, close the gap in shape and permutation
    logic [WORK-1:0][VAL_W-1:0] shp_col;
    logic [WORK-1:0][IDX_W-1:0] pr_col;
    logic [IDX_W-1:0]           pr_shift [WORK-1];

    always_comb
    begin
        for (int j = 0; j < WORK - 1; j++)
        begin
            if (IDX_W'(j) < p1_reg)
                shp_col[j] = shp_reg[j];
            else if (IDX_W'(j) == p1_reg)
                shp_col[j] = prod_reg;
            else
                shp_col[j] = shp_reg[j + 1];

            pr_shift[j] = (IDX_W'(j) <= k_reg) ? pr_reg[j] : pr_reg[j + 1];
            pr_col[j]   = (pr_shift[j] > p1_reg) ? pr_shift[j] - IDX_W'(1) : pr_shift[j];
        end
        shp_col[WORK-1] = '0;
        pr_col[WORK-1]  = '0;
    end

    // left-pad to rank four
    logic [IDX_W-1:0]             pad;
    logic [ORANK-1:0][VAL_W-1:0]  s_pad;
    logic [ORANK-1:0][OIDX_W-1:0] fp_pad;
    logic [IDX_W-1:0]             fp_wide;

    always_comb
    begin
        pad     = IDX_W'(ORANK) - n_reg;
        fp_wide = '0;
        for (int i = 0; i < ORANK; i++)
        begin
            s_pad[i]  = VAL_W'(1);
            fp_pad[i] = OIDX_W'(i);
            for (int j = 0; j < ORANK; j++)
            begin
                if (IDX_W'(j) + pad == IDX_W'(i))
                begin
                    s_pad[i]  = shp_reg[j];
                    fp_wide   = pr_reg[j] + pad;
                    fp_pad[i] = fp_wide[OIDX_W-1:0];
                end
            end
        end
    end

    logic [OIDX_W-1:0] q;
    assign q = fp_reg[cnt_reg];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (found)
                    state_next = ST_COLLAPSE;
                else if (n_reg > IDX_W'(ORANK))
                    state_next = ST_DONE;
                else
                    state_next = ST_PAD;
            end
            ST_COLLAPSE:
            begin
                state_next = ST_SCAN;
            end
            ST_PAD:
            begin
                state_next = ST_STRIDE;
                cnt_next   = OIDX_W'(ORANK - 1);
            end
            ST_STRIDE:
            begin
                if (cnt_reg == OIDX_W'(1))
                begin
                    state_next = ST_PERM;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg - OIDX_W'(1);
                end
            end
            ST_PERM:
            begin
                cnt_next = cnt_reg + OIDX_W'(1);
                if (cnt_reg == OIDX_W'(ORANK - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free or being emptied
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    out_load       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    shp_reg <= prep.shp;
                    pr_reg  <= prep.pr;
                    n_reg   <= prep.n;
                end
            end
            ST_SCAN:
            begin
                prod_reg <= mul_y;
                k_reg    <= k_sel;
                p1_reg   <= p1_sel;
                if (!found)
                    stat_reg <= (n_reg > IDX_W'(ORANK)) ? trdr_pkg::STATUS_RANK
                                                        : trdr_pkg::STATUS_OK;
            end
            ST_COLLAPSE:
            begin
                shp_reg <= shp_col;
                pr_reg  <= pr_col;
                n_reg   <= n_reg - IDX_W'(1);
            end
            ST_PAD:
            begin
                s_reg            <= s_pad;
                fp_reg           <= fp_pad;
                acc_reg          <= VAL_W'(1);
                off_reg[ORANK-1] <= VAL_W'(1);
            end
            ST_STRIDE:
            begin
                // advance the running product from the innermost dimension out
                acc_reg                        <= mul_y;
                off_reg[cnt_reg - OIDX_W'(1)]  <= mul_y;
            end
            ST_PERM:
            begin
                stg_stride_reg[cnt_reg] <= off_reg[q][FIELD_W-1:0];
                stg_tshape_reg[cnt_reg] <= s_reg[q][FIELD_W-1:0];
                if (off_reg[q][VAL_W-1] || s_reg[q][VAL_W-1])
                    stat_reg <= trdr_pkg::STATUS_OVF;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    out_status_reg <= stat_reg;
                    for (int i = 0; i < ORANK; i++)
                    begin
                        // drop all fields on any failure
                        out_stride_reg[i] <= (stat_reg == trdr_pkg::STATUS_OK)
                                             ? stg_stride_reg[i] : '0;
                        out_tshape_reg[i] <= (stat_reg == trdr_pkg::STATUS_OK)
                                             ? stg_tshape_reg[i] : '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign status    = out_status_reg;
    assign stride0   = out_stride_reg[0];
    assign stride1   = out_stride_reg[1];
    assign stride2   = out_stride_reg[2];
    assign stride3   = out_stride_reg[3];
    assign tshape0   = out_tshape_reg[0];
    assign tshape1   = out_tshape_reg[1];
    assign tshape2   = out_tshape_reg[2];
    assign tshape3   = out_tshape_reg[3];

    // every collapse removes exactly one dimension
    a_collapse_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COLLAPSE |=> n_reg == $past(n_reg) - IDX_W'(1))
        else $error("collapse did not remove one dimension");

    // the working rank stays within the survivors plus the byte dimension
    a_scan_rank_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> (n_reg != '0 && n_reg <= IDX_W'(WORK)))
        else $error("working rank out of range");

    // too many remaining dimensions goes straight to the result with rank status
    a_rank_path: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && !found && n_reg > IDX_W'(ORANK))
        |=> (state_reg == ST_DONE && stat_reg == trdr_pkg::STATUS_RANK))
        else $error("rank failure not routed to result");

    // a failed transaction carries no strides or extents; lanes 0 and 3 are checked
    a_fail_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != trdr_pkg::STATUS_OK)
        |-> (stride0 == '0 && stride3 == '0 && tshape0 == '0 && tshape3 == '0))
        else $error("failed result carries nonzero fields");

    // a response only appears out of the final state
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside the final state");

endmodule
